// ===== src/pafo_pkg.sv =====
package pafo_pkg;

  localparam int unsigned ADC_W      = 10;
  localparam int unsigned IN_TDATA_W = 16;
  localparam int unsigned P_W        = 16;
  // The window length must be a power of two; the mean is a rounding shift.
  localparam int unsigned WINDOW     = 16;
  localparam int unsigned WIN_W      = $clog2(WINDOW);
  localparam int unsigned SUM_W      = P_W + WIN_W;
  localparam int unsigned SCALE_W    = 20;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FLOW_W     = 25;
  localparam int unsigned PROD_W     = 31;
  localparam int unsigned RAD_W      = 28;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned CNT_W      = $clog2(ROOT_W);
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned KPA_Q16    = 6427;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_ADC_ZERO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_GAIN = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  function automatic logic signed [P_W-1:0] sat_p(input logic signed [24:0] v);
    logic signed [P_W-1:0] r;
    if (v > 25'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -25'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[P_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/pafo_isqrt.sv =====
module pafo_isqrt import pafo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign rem_shift = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial     = {root_q, 2'b01};
  assign ge        = (rem_shift >= trial);
  assign done_o    = busy_q && (cnt_q == CNT_W'(ROOT_W - 1));
  assign root_o    = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_shift - trial) : rem_shift;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== src/pressure_average_and_orifice_flow.sv =====
// Pressure averaging filter with square-root orifice flow.
// The slave stream takes one converter sample per word in s_axis_tdata[9:0].
// Each sample becomes a Q7.8 cmH2O pressure, enters a 16-entry averaging
// window, and the filtered pressure yields a signed Q16.8 flow value.
// The master stream returns one word per sample: raw pressure, filtered
// pressure and flow in m_axis_tdata, and the window-full flag in m_axis_tuser.
// One shared multiplier and a bit-pair square-root unit do the work under a
// small sequencer; the square root takes most of the time from acceptance to
// the result register.
// s_axis_tready is high only while the sequencer is idle, so a new sample is
// taken only after the last one has reached the output register.
// A finished word waits in the output register; if the receiver stalls, the
// next sample is still accepted and processed, and its result waits at the
// final step until the output register frees up.
// Configuration words are accepted in every cycle and must only be written
// while no sample is in flight. Reset empties the window, clears the
// registers and sets the flow gain to 1.0.
module pressure_average_and_orifice_flow import pafo_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] adc_sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] raw_pressure, [31:16] filtered_pressure, [56:32] flow_rate
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]             m_axis_tuser,  // [0] filter_ready
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MULP = 4'd1;
  localparam logic [3:0] ST_RAW  = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_FILT = 4'd4;
  localparam logic [3:0] ST_MAG  = 4'd5;
  localparam logic [3:0] ST_SQST = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_GAIN = 4'd8;
  localparam logic [3:0] ST_FLOW = 4'd9;

  logic [3:0] state_q, state_d;

  logic [ADC_W-1:0]          zero_q;
  logic [SCALE_W-1:0]        scale_q;
  logic signed [P_W-1:0]     offset_q;
  logic [GAIN_W-1:0]         gain_q;

  logic signed [ADC_W:0]     diff_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [P_W-1:0]     raw_q;
  logic signed [P_W-1:0]     filt_q;
  logic signed [P_W-1:0]     ring_q [WINDOW];
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [WIN_W-1:0]          pos_q;
  logic                      full_q;

  logic                      out_valid_q;
  logic signed [P_W-1:0]     out_raw_q;
  logic signed [P_W-1:0]     out_filt_q;
  logic [FLOW_W-1:0]         out_flow_q;
  logic                      out_full_q;

  logic signed [17:0]        mul_a;
  logic signed [20:0]        mul_b;
  logic signed [38:0]        mul_p;
  logic [P_W:0]              filt_mag;
  logic signed [31:0]        raw_rnd;
  logic signed [24:0]        raw_sum;
  logic signed [P_W-1:0]     ring_old;
  logic signed [SUM_W:0]     mean_rnd;
  logic signed [SUM_W:0]     mean;
  logic [36:0]               flow_x;
  logic [36:0]               flow_60;
  logic [FLOW_W-1:0]         flow_w;
  logic [FLOW_W-2:0]         flow_mag;
  logic [FLOW_W-1:0]         flow_val;
  logic                      out_load;
  logic                      sq_start;
  logic                      sq_done;
  logic [ROOT_W-1:0]         sq_root;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q   <= '0;
      scale_q  <= '0;
      offset_q <= '0;
      gain_q   <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ADC_ZERO:  zero_q   <= cfg_data_i[ADC_W-1:0];
        CFG_SCALE:     scale_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_OFFSET:    offset_q <= cfg_data_i[P_W-1:0];
        CFG_FLOW_GAIN: gain_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      ST_MULP: begin
        mul_a = 18'(diff_q);
        mul_b = {1'b0, scale_q};
      end
      ST_MAG: begin
        mul_a = {1'b0, filt_mag};
        mul_b = 21'(KPA_Q16);
      end
      default: begin
        mul_a = {4'b0, sq_root};
        mul_b = {5'b0, gain_q};
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign filt_mag = filt_q[P_W-1] ? (17'd0 - {filt_q[P_W-1], filt_q}) : {1'b0, filt_q};

  assign raw_rnd  = 32'(prod_q) + 32'sd128;
  assign raw_sum  = 25'(raw_rnd >>> 8) + 25'(offset_q);

  assign ring_old = full_q ? ring_q[pos_q] : '0;
  assign sum_d    = sum_q - SUM_W'(ring_old) + SUM_W'(raw_q);
  assign mean_rnd = (SUM_W+1)'(sum_q) + (SUM_W+1)'(WINDOW / 2);
  assign mean     = mean_rnd >>> WIN_W;

  assign flow_x   = {7'b0, prod_q[29:0]};
  assign flow_60  = (flow_x << 6) - (flow_x << 2) + 37'd2048;
  assign flow_w   = flow_60[36:12];
  assign flow_mag = flow_w[FLOW_W-1] ? '1 : flow_w[FLOW_W-2:0];
  assign flow_val = (filt_q > 16'sd0) ? {1'b0, flow_mag} : (25'd0 - {1'b0, flow_mag});

  assign out_load = (state_q == ST_FLOW) && (!out_valid_q || m_axis_tready);
  assign sq_start = (state_q == ST_SQST);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_MULP;
      ST_MULP: state_d = ST_RAW;
      ST_RAW:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_FILT;
      ST_FILT: state_d = ST_MAG;
      ST_MAG:  state_d = ST_SQST;
      ST_SQST: state_d = ST_SQRT;
      ST_SQRT: if (sq_done) state_d = ST_GAIN;
      ST_GAIN: state_d = ST_FLOW;
      ST_FLOW: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      pos_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        sum_q <= sum_d;
        if (pos_q == WIN_W'(WINDOW - 1)) begin
          pos_q  <= '0;
          full_q <= 1'b1;
        end else begin
          pos_q <= pos_q + WIN_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      diff_q <= $signed({1'b0, s_axis_tdata[ADC_W-1:0]}) - $signed({1'b0, zero_q});
    end
    if (state_q == ST_MULP || state_q == ST_MAG || state_q == ST_GAIN) begin
      prod_q <= mul_p[PROD_W-1:0];
    end
    if (state_q == ST_RAW) begin
      raw_q <= sat_p(raw_sum);
    end
    if (state_q == ST_ACC) begin
      ring_q[pos_q] <= raw_q;
    end
    if (state_q == ST_FILT) begin
      filt_q <= full_q ? sat_p(25'(mean)) : raw_q;
    end
    if (out_load) begin
      out_raw_q  <= raw_q;
      out_filt_q <= filt_q;
      out_flow_q <= flow_val;
      out_full_q <= full_q;
    end
  end

  pafo_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (prod_q[RAD_W-1:0]),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_flow_q, out_filt_q, out_raw_q};
  assign m_axis_tuser  = out_full_q;

endmodule

// ===== src/pafo_checker.sv =====
module pafo_checker import pafo_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser
);

  logic seen_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_full_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[0]) begin
      seen_full_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  a_full_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && seen_full_q |-> m_axis_tuser[0])
    else $error("filter_ready dropped after the window filled");

  a_unfilled_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:16] == m_axis_tdata[15:0])
    else $error("filtered pressure differs from raw before the window filled");

  a_flow_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[31] || m_axis_tdata[31:16] == 16'd0) |->
      (m_axis_tdata[56] || m_axis_tdata[56:32] == 25'd0))
    else $error("flow is positive for a pressure that is not positive");

endmodule

bind pressure_average_and_orifice_flow pafo_checker u_pafo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/pafo_flow_checker.sv =====
`timescale 1ns / 100ps

module pafo_flow_checker import pafo_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] adc_sample
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] raw_pressure, [31:16] filtered_pressure, [56:32] flow_rate
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [0:0]             m_axis_tuser,   // [0] filter_ready
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     pending_o,
  output int                     errors_o
);

  localparam longint unsigned FLOW_FACTOR = 60;
  localparam longint unsigned FLOW_LIMIT  = (64'd1 << (FLOW_W - 1)) - 1;

  typedef struct packed {
    logic signed [P_W-1:0]    raw_p;
    logic signed [P_W-1:0]    filt_p;
    logic signed [FLOW_W-1:0] flow;
    logic                     full;
  } flow_word_t;

  flow_word_t expected_words[$];
  flow_word_t want;

  logic [ADC_W-1:0]      zero_cnt;
  logic [SCALE_W-1:0]    scale_q16;
  logic signed [P_W-1:0] offset_q8;
  logic [GAIN_W-1:0]     gain_q8;

  logic signed [P_W-1:0] window_ring [WINDOW];
  longint                window_total;
  int unsigned           fill_pos;
  logic                  window_filled;

  int mismatches = 0;

  assign errors_o = mismatches;

  function automatic longint clip_q8(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  function automatic flow_word_t predict_flow(input logic [ADC_W-1:0] adc);
    flow_word_t      w;
    longint          prod;
    longint          p;
    longint          filt;
    longint          flow;
    longint unsigned mag;
    longint unsigned root;
    longint unsigned fmag;
    prod = (longint'(adc) - longint'(zero_cnt)) * longint'(scale_q16);
    p = clip_q8(((prod + 128) >>> 8) + longint'(offset_q8));
    window_total = window_total - longint'(window_ring[fill_pos]) + p;
    window_ring[fill_pos] = p[P_W-1:0];
    if (fill_pos == WINDOW - 1) begin
      fill_pos = 0;
      window_filled = 1'b1;
    end else begin
      fill_pos++;
    end
    if (window_filled) begin
      filt = clip_q8((window_total + longint'(WINDOW / 2)) >>> WIN_W);
    end else begin
      filt = p;
    end
    mag = (filt < 0) ? -filt : filt;
    mag = mag * KPA_Q16;
    root = root_floor(mag);
    fmag = (root * FLOW_FACTOR * gain_q8 + 2048) >> 12;
    if (fmag > FLOW_LIMIT) begin
      fmag = FLOW_LIMIT;
    end
    flow = (filt > 0) ? longint'(fmag) : -longint'(fmag);
    w.raw_p  = p[P_W-1:0];
    w.filt_p = filt[P_W-1:0];
    w.flow   = flow[FLOW_W-1:0];
    w.full   = window_filled;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, exp_v);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_cnt      = '0;
      scale_q16     = '0;
      offset_q8     = '0;
      gain_q8       = GAIN_RESET;
      window_total  = 0;
      fill_pos      = 0;
      window_filled = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        window_ring[i] = '0;
      end
      expected_words.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ADC_ZERO:  zero_cnt  = cfg_data_i[ADC_W-1:0];
          CFG_SCALE:     scale_q16 = cfg_data_i[SCALE_W-1:0];
          CFG_OFFSET:    offset_q8 = cfg_data_i[P_W-1:0];
          CFG_FLOW_GAIN: gain_q8   = cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(predict_flow(s_axis_tdata[ADC_W-1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing pending",
                          $signed(m_axis_tdata[P_W-1:0]), 0);
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[P_W-1:0] !== want.raw_p) begin
            report_mismatch("raw_pressure", $signed(m_axis_tdata[P_W-1:0]), want.raw_p);
          end
          if (m_axis_tdata[2*P_W-1:P_W] !== want.filt_p) begin
            report_mismatch("filtered_pressure", $signed(m_axis_tdata[2*P_W-1:P_W]),
                            want.filt_p);
          end
          if (m_axis_tdata[32+FLOW_W-1:32] !== want.flow) begin
            report_mismatch("flow_rate", $signed(m_axis_tdata[32+FLOW_W-1:32]), want.flow);
          end
          if (m_axis_tuser[0] !== want.full) begin
            report_mismatch("filter_ready", m_axis_tuser[0], want.full);
          end
        end
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

// ===== sim/pressure_average_and_orifice_flow_tb.sv =====
`timescale 1ns / 100ps

module pressure_average_and_orifice_flow_tb;
  import pafo_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASES        = 8;
  localparam int PHASE_SAMPLES = 225;
  localparam int HOLD_PHASE    = 4;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  int pending_words;
  int error_count;
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_requests = 0;
  int cycle_count = 0;
  logic [ADC_W-1:0] cur_zero = '0;

  pressure_average_and_orifice_flow u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pafo_flow_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending_words),
    .errors_o      (error_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // A new hold request makes the sink refuse words for a long stretch.
  initial begin
    int seen;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != seen) begin
        seen = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_sample(input logic [ADC_W-1:0] adc);
    logic [IN_TDATA_W-1:0] junk;
    junk = IN_TDATA_W'($urandom);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {junk[IN_TDATA_W-1:ADC_W], adc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Bits above each register's width carry noise; the block must drop them.
  task automatic apply_config(input logic [ADC_W-1:0] zero, input logic [SCALE_W-1:0] scale,
                              input logic [P_W-1:0] offset, input logic [GAIN_W-1:0] gain);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_ADC_ZERO, {junk[CFG_DATA_W-1:ADC_W], zero});
    write_reg(CFG_SCALE, scale);
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_OFFSET, {junk[CFG_DATA_W-1:P_W], offset});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_FLOW_GAIN, {junk[CFG_DATA_W-1:GAIN_W], gain});
    cfg_valid_i <= 1'b0;
    cur_zero = zero;
  endtask

  task automatic random_config();
    logic [ADC_W-1:0]   z;
    logic [SCALE_W-1:0] sc;
    logic [P_W-1:0]     off;
    logic [GAIN_W-1:0]  g;
    case ($urandom_range(0, 3))
      0:       z = '0;
      1:       z = '1;
      default: z = ADC_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       sc = '0;
      1:       sc = '1;
      2, 3:    sc = SCALE_W'($urandom);
      default: sc = SCALE_W'($urandom_range(0, 'h2000));
    endcase
    case ($urandom_range(0, 5))
      0:       off = 16'h7FFF;
      1:       off = 16'h8000;
      2, 3:    off = P_W'($urandom);
      default: off = P_W'($urandom_range(0, 2047) - 1024);
    endcase
    case ($urandom_range(0, 4))
      0:       g = '0;
      1:       g = '1;
      default: g = GAIN_W'($urandom);
    endcase
    apply_config(z, sc, off, g);
  endtask

  function automatic logic [ADC_W-1:0] pick_sample();
    int               r;
    int               near;
    logic [ADC_W-1:0] s;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      s = ADC_W'($urandom);
    end else if (r < 9) begin
      near = int'(cur_zero) + int'($urandom_range(0, 16)) - 8;
      if (near < 0) begin
        near = 0;
      end else if (near > 1023) begin
        near = 1023;
      end
      s = ADC_W'(near);
    end else begin
      s = $urandom_range(0, 1) ? '1 : '0;
    end
    return s;
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    drain();

    // Zero count at midscale: negative, zero and positive pressure.
    apply_config(10'd512, 20'h10000, 16'h0000, GAIN_RESET);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    send_sample(10'd511);
    send_sample(10'd513);
    drain();

    // Full scale with extreme offsets drives the pressure into saturation.
    apply_config(10'd0, 20'hFFFFF, 16'h7FFF, 16'hFFFF);
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd1);
    drain();

    apply_config(10'd1023, 20'hFFFFF, 16'h8000, 16'h0000);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1022);
    drain();

    apply_config(10'd0, 20'h10000, 16'h0000, GAIN_RESET);
    send_sample(10'd1);
    send_sample(10'd2);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          sender_idle_pct <= 0;
          sink_stall_pct  <= 0;
        end
        1: begin
          sender_idle_pct <= 87;
          sink_stall_pct  <= 0;
        end
        2: begin
          sender_idle_pct <= 0;
          sink_stall_pct  <= 87;
        end
        default: begin
          sender_idle_pct <= 9;
          sink_stall_pct  <= 9;
        end
      endcase
      random_config();
      if (p == HOLD_PHASE) begin
        hold_requests <= hold_requests + 1;
      end
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        send_sample(pick_sample());
      end
      drain();
    end

    if (error_count == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
